/* src/phrase_pair_cosine_similarity_unit_assert.svh */
// Assertion macros shared by the phrase pair cosine similarity unit.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef PHRASE_PAIR_COSINE_SIMILARITY_UNIT_ASSERT_SVH
`define PHRASE_PAIR_COSINE_SIMILARITY_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppcs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PPCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ppcs assertion failed");

`endif

/* src/ppcs_pkg.sv */
// Shared types, constants and helpers of the phrase pair cosine similarity unit.
// No dependencies.
`default_nettype none
package ppcs_pkg;

  localparam int unsigned IdW  = 20;
  localparam int unsigned DfW  = 24;
  localparam int unsigned WgtW = 24;

  localparam logic [1:0] MODE_TFIDF = 2'd0;
  localparam logic [1:0] MODE_DF    = 2'd1;

  localparam logic CFG_DOC_COUNT   = 1'b0;
  localparam logic CFG_WEIGHT_MODE = 1'b1;

  localparam logic OP_TERM_A = 1'b0;

  // ln 2 in Q0.32 and the 0.01 offset in Q5.11.
  localparam logic [31:0]   LN2_Q032    = 32'd2977044472;
  localparam logic [WgtW-1:0] OFFSET_Q511 = 24'd20;

  typedef struct packed {
    logic            opcode;
    logic [IdW-1:0]  term_id;
    logic [WgtW-1:0] weight;
    logic            last;
  } item_t;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage
`default_nettype wire

/* src/ppcs_front.sv */
// Front end: takes input beats and works out each term's weight.
// Uses ppcs_pkg; feeds ppcs_queue.
`default_nettype none
module ppcs_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        opcode_i,
  input  wire logic [ppcs_pkg::IdW-1:0]    term_id_i,
  input  wire logic [ppcs_pkg::DfW-1:0]    doc_freq_i,
  input  wire logic                        last_i,
  input  wire logic [ppcs_pkg::DfW-1:0]    doc_count_i,
  input  wire logic [1:0]                  weight_mode_i,
  output logic                             q_push_o,
  output ppcs_pkg::item_t                  q_item_o,
  input  wire logic                        q_full_i
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_DIV  = 3'd1;
  localparam logic [2:0] F_LOGI = 3'd2;
  localparam logic [2:0] F_SQ   = 3'd3;
  localparam logic [2:0] F_SQA  = 3'd4;
  localparam logic [2:0] F_LN   = 3'd5;
  localparam logic [2:0] F_LNA  = 3'd6;
  localparam logic [2:0] F_PUSH = 3'd7;

  logic [2:0]  state_q, state_d;
  logic        op_q;
  logic [ppcs_pkg::IdW-1:0] id_q;
  logic [ppcs_pkg::DfW-1:0] df_q;
  logic        last_q;
  logic [ppcs_pkg::WgtW-1:0] w_q, w_d;
  logic [24:0] rem_q, rem_d;
  logic [23:0] quot_q, quot_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [4:0]  k_q, k_d;
  logic [31:0] x_q, x_d;
  logic [15:0] frac_q, frac_d;
  logic [63:0] prod_q;
  logic [52:0] lnp_q;
  logic [24:0] rem_try;
  logic [4:0]  msb;
  logic [33:0] sq_sh;
  logic [52:0] ln_rnd;
  logic        accept;

  assign full     = (state_q != F_IDLE);
  assign accept   = push && !full;
  assign q_push_o = (state_q == F_PUSH) && !q_full_i;
  assign q_item_o = '{opcode: op_q, term_id: id_q, weight: w_q, last: last_q};

  always_comb begin
    msb = '0;
    for (int i = 0; i < 24; i++) begin
      if (quot_q[i]) msb = 5'(i);
    end
  end

  assign rem_try = {rem_q[23:0], quot_q[23]};
  assign sq_sh   = prod_q[63:30];
  assign ln_rnd  = lnp_q + (53'd1 << 36);

  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    x_d     = x_q;
    frac_d  = frac_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (doc_freq_i == '0) begin
            w_d = '0;
            state_d = F_PUSH;
          end else if (weight_mode_i == ppcs_pkg::MODE_DF) begin
            w_d = doc_freq_i;
            state_d = F_PUSH;
          end else if (weight_mode_i != ppcs_pkg::MODE_TFIDF) begin
            w_d = 24'd1;
            state_d = F_PUSH;
          end else begin
            rem_d   = '0;
            quot_d  = doc_count_i;
            cnt_d   = 5'd24;
            state_d = F_DIV;
          end
        end
      end
      F_DIV: begin
        if (rem_try >= {1'b0, df_q}) begin
          rem_d  = rem_try - {1'b0, df_q};
          quot_d = {quot_q[22:0], 1'b1};
        end else begin
          rem_d  = rem_try;
          quot_d = {quot_q[22:0], 1'b0};
        end
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd1) state_d = F_LOGI;
      end
      F_LOGI: begin
        if (quot_q == '0) begin
          w_d = '0;
          state_d = F_PUSH;
        end else begin
          k_d     = msb;
          x_d     = {8'b0, quot_q} << (5'd30 - msb);
          frac_d  = '0;
          cnt_d   = 5'd16;
          state_d = F_SQ;
        end
      end
      F_SQ: state_d = F_SQA;
      F_SQA: begin
        if (sq_sh[31]) begin
          frac_d = {frac_q[14:0], 1'b1};
          x_d    = 32'(sq_sh >> 1);
        end else begin
          frac_d = {frac_q[14:0], 1'b0};
          x_d    = sq_sh[31:0];
        end
        cnt_d   = cnt_q - 5'd1;
        state_d = (cnt_q == 5'd1) ? F_LN : F_SQ;
      end
      F_LN: state_d = F_LNA;
      F_LNA: begin
        w_d     = 24'(ln_rnd[52:37]) + ppcs_pkg::OFFSET_Q511;
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      id_q   <= term_id_i;
      df_q   <= doc_freq_i;
      last_q <= last_i;
    end
    w_q    <= w_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    cnt_q  <= cnt_d;
    k_q    <= k_d;
    x_q    <= x_d;
    frac_q <= frac_d;
    prod_q <= x_q * x_q;
    lnp_q  <= 53'({k_q, frac_q}) * 53'(ppcs_pkg::LN2_Q032);
  end

endmodule
`default_nettype wire

/* src/ppcs_queue.sv */
// Two-entry queue of weighted terms between the front and back ends.
// Uses ppcs_pkg.
`default_nettype none
module ppcs_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ppcs_pkg::item_t item_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output ppcs_pkg::item_t      item_o,
  output logic                 empty_o
);

  ppcs_pkg::item_t mem_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end

endmodule
`default_nettype wire

/* src/ppcs_back.sv */
// Back end: stores phrase A, scans it for each phrase B term, and forms the result.
// Uses ppcs_pkg and the assertion macros; fed by ppcs_queue.
`default_nettype none
`include "phrase_pair_cosine_similarity_unit_assert.svh"
module ppcs_back #(
  parameter int unsigned MAX_TERMS = 64,
  parameter int unsigned ID_BITS   = 20
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ppcs_pkg::item_t item_i,
  input  wire logic            q_empty_i,
  output logic                 q_pop_o,
  output logic [15:0]          similarity_o,
  output logic [12:0]          same_count_o,
  output logic                 overflow_o,
  output logic                 empty,
  input  wire logic            pop
);

  localparam int unsigned SW = (ID_BITS < ppcs_pkg::IdW) ? ID_BITS : ppcs_pkg::IdW;
  localparam int unsigned CW = $clog2(MAX_TERMS + 1);
  localparam int unsigned AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_TERMS);

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_SQ    = 4'd1;
  localparam logic [3:0] B_APPLY = 4'd2;
  localparam logic [3:0] B_SCAN  = 4'd3;
  localparam logic [3:0] B_FIN   = 4'd4;
  localparam logic [3:0] B_MP    = 4'd5;
  localparam logic [3:0] B_MA    = 4'd6;
  localparam logic [3:0] B_SQRT  = 4'd7;
  localparam logic [3:0] B_DIV   = 4'd8;
  localparam logic [3:0] B_OUT   = 4'd9;

  logic [SW-1:0]   ids_mem [MAX_TERMS];
  logic [23:0]     wts_mem [MAX_TERMS];

  logic [3:0]      state_q;
  ppcs_pkg::item_t it_q;
  logic [47:0]     sq_q;
  logic [CW-1:0]   a_cnt_q, b_cnt_q, idx_q;
  logic [63:0]     dot_q, na_q, nb_q;
  logic [12:0]     match_q;
  logic            a_closed_q, ovf_q;
  logic            v1_q, v2_q;
  logic [SW-1:0]   rd_id_q;
  logic [23:0]     rd_w_q;
  logic [47:0]     prod_q;
  logic [1:0]      j_q;
  logic [63:0]     pp_q;
  logic [127:0]    p_q;
  logic [65:0]     srem_q;
  logic [63:0]     root_q;
  logic [63:0]     dr_q;
  logic [77:0]     nd_q;
  logic [6:0]      cnt_q;
  logic [15:0]     qv_q;
  logic            sat_q;
  logic            res_valid_q;
  logic [15:0]     res_sim_q;
  logic [12:0]     res_cnt_q;
  logic            res_ovf_q;

  logic            clr;
  logic [CW-1:0]   a_eff;
  logic            a_wr;
  logic [SW-1:0]   my_id;
  logic [67:0]     s_try, s_trial;
  logic [64:0]     d_try;
  logic [127:0]    pp_sh;
  logic [1:0]      j_amt;
  logic            res_load;

  assign my_id   = it_q.term_id[SW-1:0];
  assign clr     = a_closed_q || (b_cnt_q != '0);
  assign a_eff   = clr ? '0 : a_cnt_q;
  assign a_wr    = (state_q == B_APPLY) && (it_q.opcode == ppcs_pkg::OP_TERM_A) &&
                   (a_eff < MaxCnt);
  assign q_pop_o = (state_q == B_IDLE) && !q_empty_i;
  assign s_try   = {srem_q, p_q[127:126]};
  assign s_trial = {2'b00, root_q, 2'b01};
  assign d_try   = {dr_q, nd_q[77]};
  assign j_amt   = 2'(j_q[1]) + 2'(j_q[0]);
  assign pp_sh   = {64'b0, pp_q} << {j_amt, 5'b0};
  assign res_load = (state_q == B_OUT) && !res_valid_q;

  assign empty        = !res_valid_q;
  assign similarity_o = res_sim_q;
  assign same_count_o = res_cnt_q;
  assign overflow_o   = res_ovf_q;

  always_ff @(posedge clk_i) begin
    if (a_wr) begin
      ids_mem[a_eff[AW-1:0]] <= my_id;
      wts_mem[a_eff[AW-1:0]] <= it_q.weight;
    end
    rd_id_q <= ids_mem[idx_q[AW-1:0]];
    rd_w_q  <= wts_mem[idx_q[AW-1:0]];
    prod_q  <= rd_w_q * it_q.weight;
    sq_q    <= it_q.weight * it_q.weight;
    pp_q    <= (j_q[1] ? na_q[63:32] : na_q[31:0]) * (j_q[0] ? nb_q[63:32] : nb_q[31:0]);
    if (q_pop_o) it_q <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      a_cnt_q     <= '0;
      b_cnt_q     <= '0;
      idx_q       <= '0;
      dot_q       <= '0;
      na_q        <= '0;
      nb_q        <= '0;
      match_q     <= '0;
      a_closed_q  <= 1'b0;
      ovf_q       <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      j_q         <= '0;
      p_q         <= '0;
      srem_q      <= '0;
      root_q      <= '0;
      dr_q        <= '0;
      nd_q        <= '0;
      cnt_q       <= '0;
      qv_q        <= '0;
      sat_q       <= 1'b0;
      res_valid_q <= 1'b0;
      res_sim_q   <= '0;
      res_cnt_q   <= '0;
      res_ovf_q   <= 1'b0;
    end else begin
      if (pop && res_valid_q) res_valid_q <= 1'b0;
      // Scan pipeline: memory read, then compare and multiply, then accumulate.
      v1_q <= 1'b0;
      v2_q <= v1_q && (rd_id_q == my_id);
      if (v2_q) begin
        dot_q <= ppcs_pkg::sat_add64(dot_q, {16'b0, prod_q});
        if (match_q != 13'h1fff) match_q <= match_q + 13'd1;
      end
      case (state_q)
        B_IDLE: begin
          if (!q_empty_i) state_q <= B_SQ;
        end
        B_SQ: state_q <= B_APPLY;
        B_APPLY: begin
          if (it_q.opcode == ppcs_pkg::OP_TERM_A) begin
            if (clr) begin
              b_cnt_q <= '0;
              dot_q   <= '0;
              nb_q    <= '0;
              match_q <= '0;
              ovf_q   <= 1'b0;
            end
            if (a_wr) begin
              a_cnt_q <= a_eff + CW'(1);
              na_q    <= clr ? {16'b0, sq_q} : ppcs_pkg::sat_add64(na_q, {16'b0, sq_q});
            end else begin
              ovf_q <= 1'b1;
            end
            a_closed_q <= it_q.last;
            state_q    <= B_IDLE;
          end else begin
            a_closed_q <= 1'b1;
            if (b_cnt_q < MaxCnt) begin
              b_cnt_q <= b_cnt_q + CW'(1);
              nb_q    <= ppcs_pkg::sat_add64(nb_q, {16'b0, sq_q});
              idx_q   <= '0;
              state_q <= B_SCAN;
            end else begin
              ovf_q   <= 1'b1;
              state_q <= it_q.last ? B_FIN : B_IDLE;
            end
          end
        end
        B_SCAN: begin
          if (idx_q < a_cnt_q) begin
            v1_q  <= 1'b1;
            idx_q <= idx_q + CW'(1);
          end else if (!v1_q && !v2_q) begin
            state_q <= it_q.last ? B_FIN : B_IDLE;
          end
        end
        B_FIN: begin
          p_q <= '0;
          j_q <= '0;
          if (dot_q == '0 || na_q == '0 || nb_q == '0) begin
            qv_q    <= '0;
            sat_q   <= 1'b0;
            state_q <= B_OUT;
          end else begin
            state_q <= B_MP;
          end
        end
        B_MP: state_q <= B_MA;
        B_MA: begin
          p_q <= p_q + pp_sh;
          j_q <= j_q + 2'd1;
          if (j_q == 2'd3) begin
            srem_q  <= '0;
            root_q  <= '0;
            cnt_q   <= 7'd64;
            state_q <= B_SQRT;
          end else begin
            state_q <= B_MP;
          end
        end
        B_SQRT: begin
          if (s_try >= s_trial) begin
            srem_q <= 66'(s_try - s_trial);
            root_q <= {root_q[62:0], 1'b1};
          end else begin
            srem_q <= 66'(s_try);
            root_q <= {root_q[62:0], 1'b0};
          end
          p_q   <= p_q << 2;
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd1) begin
            dr_q    <= '0;
            nd_q    <= {dot_q, 14'b0};
            qv_q    <= '0;
            sat_q   <= 1'b0;
            cnt_q   <= 7'd78;
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          if (d_try >= {1'b0, root_q}) begin
            dr_q <= 64'(d_try - {1'b0, root_q});
            qv_q <= {qv_q[14:0], 1'b1};
          end else begin
            dr_q <= d_try[63:0];
            qv_q <= {qv_q[14:0], 1'b0};
          end
          sat_q <= sat_q || qv_q[15];
          nd_q  <= nd_q << 1;
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd1) state_q <= B_OUT;
        end
        B_OUT: begin
          if (!res_valid_q) begin
            res_valid_q <= 1'b1;
            res_sim_q   <= sat_q ? 16'hffff : qv_q;
            res_cnt_q   <= match_q;
            res_ovf_q   <= ovf_q;
            a_cnt_q     <= '0;
            b_cnt_q     <= '0;
            dot_q       <= '0;
            na_q        <= '0;
            nb_q        <= '0;
            match_q     <= '0;
            a_closed_q  <= 1'b0;
            ovf_q       <= 1'b0;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  `PPCS_ASSERT_NOW(a_cnt_in_range, 1'b1, a_cnt_q <= MaxCnt)
  `PPCS_ASSERT_NOW(scan_in_range, state_q == B_SCAN, idx_q <= a_cnt_q)
  `PPCS_ASSERT_NEXT(result_loaded, res_load, res_valid_q && state_q == B_IDLE && a_cnt_q == '0)

endmodule
`default_nettype wire

/* src/phrase_pair_cosine_similarity_unit.sv */
// Top level of the phrase pair cosine similarity unit: configuration, front, queue, back.
// Uses ppcs_pkg, ppcs_front, ppcs_queue and ppcs_back.
//
// Phrase A terms (opcode 0) are pushed first and stored with their weights, up to
// MAX_TERMS of them; phrase B terms (opcode 1) follow, and a B term with last set
// produces one result beat: the cosine similarity in unsigned Q2.14, the number of
// matching id pairs and an overflow flag. The front end takes one beat at a time and
// computes its weight: directly in the document frequency and unit modes, and in
// tf_idf mode by a 24-step quotient, then 16 squaring steps, each a multiply and an
// apply state, for the logarithm. A two-entry queue decouples it from the back end,
// which stores each A term and, for each B term, scans the A store, one memory read
// port, one entry per cycle. A closing B term then goes through four 32x32 partial
// products for the norm product, a 64-step square root and a 78-step divide, unless
// the dot product or a norm is zero. The result waits in an output register, so the
// next pair may proceed while it is not yet popped.
// Configuration (doc_count at index 0, weight_mode at index 1) must only be written
// while the block is idle.
`default_nettype none
module phrase_pair_cosine_similarity_unit #(
  parameter int unsigned MAX_TERMS = 64,
  parameter int unsigned ID_BITS   = 20
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_addr_i,
  input  wire logic [23:0]               cfg_wdata_i,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic                      opcode_i,
  input  wire logic [ppcs_pkg::IdW-1:0]  term_id_i,
  input  wire logic [ppcs_pkg::DfW-1:0]  doc_freq_i,
  input  wire logic                      last_i,
  output logic                           empty,
  input  wire logic                      pop,
  output logic [15:0]                    similarity_o,
  output logic [12:0]                    same_count_o,
  output logic                           overflow_o
);

  logic [23:0]     doc_count_q;
  logic [1:0]      weight_mode_q;
  logic            fq_push, fq_full, bq_pop, bq_empty;
  ppcs_pkg::item_t fq_item, bq_item;

  // Configuration registers; the weight of a term uses the values at its arrival.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      doc_count_q   <= 24'd1;
      weight_mode_q <= ppcs_pkg::MODE_TFIDF;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        ppcs_pkg::CFG_DOC_COUNT:   doc_count_q   <= cfg_wdata_i;
        ppcs_pkg::CFG_WEIGHT_MODE: weight_mode_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  ppcs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .opcode_i      (opcode_i),
    .term_id_i     (term_id_i),
    .doc_freq_i    (doc_freq_i),
    .last_i        (last_i),
    .doc_count_i   (doc_count_q),
    .weight_mode_i (weight_mode_q),
    .q_push_o      (fq_push),
    .q_item_o      (fq_item),
    .q_full_i      (fq_full)
  );

  ppcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .item_i  (fq_item),
    .full_o  (fq_full),
    .pop_i   (bq_pop),
    .item_o  (bq_item),
    .empty_o (bq_empty)
  );

  ppcs_back #(
    .MAX_TERMS (MAX_TERMS),
    .ID_BITS   (ID_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (bq_item),
    .q_empty_i    (bq_empty),
    .q_pop_o      (bq_pop),
    .similarity_o (similarity_o),
    .same_count_o (same_count_o),
    .overflow_o   (overflow_o),
    .empty        (empty),
    .pop          (pop)
  );

endmodule
`default_nettype wire
